@@ design/pidm_pkg.sv @@
// pidm_pkg: shared types, constants and helpers of the pid controller
// holds the tanh table, the command and status types and the saturation helper
// no dependencies
package pidm_pkg;

   localparam int FRACTION_BITS      = 16;
   localparam int TANH_TABLE_ENTRIES = 256;
   localparam int TANH_IDX_W         = $clog2(TANH_TABLE_ENTRIES + 1);
   localparam int POS_FRAC           = 16;
   localparam int ALPHA_Q16          = 6554;
   localparam int MUL_W              = 34;
   localparam int PROD_W             = 2 * MUL_W;
   localparam int DIV_NUM_W          = 64;
   localparam int DIV_DEN_W          = 34;
   localparam int DIV_CNT_W          = $clog2(DIV_NUM_W);

   localparam logic [23:0] KP_RESET    = 24'd131072;
   localparam logic [23:0] KI_RESET    = 24'd32768;
   localparam logic [23:0] KD_RESET    = 24'd6554;
   localparam logic [31:0] ILOW_RESET  = 32'hFFF6_0000;
   localparam logic [31:0] IHIGH_RESET = 32'd655360;

   typedef enum logic [2:0] {
      CSR_KP    = 3'd0,
      CSR_KI    = 3'd1,
      CSR_KD    = 3'd2,
      CSR_ILOW  = 3'd3,
      CSR_IHIGH = 3'd4,
      CSR_IMODE = 3'd5,
      CSR_SMODE = 3'd6,
      CSR_DMODE = 3'd7
   } csr_index_type;

   localparam logic [1:0] SAT_CLAMP = 2'd0;
   localparam logic [1:0] SAT_NONE  = 2'd1;
   localparam logic [1:0] SAT_TANH  = 2'd2;

   localparam logic IMODE_EULER     = 1'b0;
   localparam logic IMODE_TRAPEZOID = 1'b1;
   localparam logic DMODE_RAW       = 1'b0;
   localparam logic DMODE_FILTERED  = 1'b1;

   typedef enum logic [4:0] {
      CMD_NONE  = 5'd0,
      CMD_LOAD  = 5'd1,
      CMD_ERR   = 5'd2,
      CMD_IMUL  = 5'd3,
      CMD_IADD  = 5'd4,
      CMD_TDIV  = 5'd5,
      CMD_TINT  = 5'd6,
      CMD_TSUM  = 5'd7,
      CMD_THMUL = 5'd8,
      CMD_TFIN  = 5'd9,
      CMD_DDIV  = 5'd10,
      CMD_DRAW  = 5'd11,
      CMD_DFMUL = 5'd12,
      CMD_DFADD = 5'd13,
      CMD_MP    = 5'd14,
      CMD_MI    = 5'd15,
      CMD_MD    = 5'd16,
      CMD_MA    = 5'd17,
      CMD_OUT   = 5'd18,
      CMD_CLR   = 5'd19
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic tanh_on;
      logic dt_zero;
   } dp_status_type;

   typedef logic [30:0] tanh_rom_type [0:TANH_TABLE_ENTRIES];

   // long division by shift and subtract, used only while building the table
   function automatic longint unsigned const_udiv(longint unsigned num,
                                                  longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   // tanh over x = 4*i/n in q0.30: series for exp(-i/n), squared three times
   function automatic tanh_rom_type tanh_rom_build();
      tanh_rom_type rom;
      longint w;
      longint term;
      longint e;
      longint p;
      longint unsigned pm;
      longint unsigned q;
      longint unsigned num;
      longint unsigned den;
      longint unsigned ui;
      for (int i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
         ui   = longint'(i);
         w    = longint'(const_udiv(ui << 30, longint'(TANH_TABLE_ENTRIES)));
         term = 64'sd1 <<< 30;
         e    = 64'sd1 <<< 30;
         for (int k = 1; k <= 20; k++) begin
            p    = term * w;
            p    = (p + (64'sd1 <<< 29)) >>> 30;
            // quotient truncated toward zero, then negated
            pm   = (p < 0) ? longint'(-p) : longint'(p);
            q    = const_udiv(pm, longint'(k));
            term = (p < 0) ? longint'(q) : -longint'(q);
            e    = e + term;
         end
         if (e < 0) e = 0;
         if (e > (64'sd1 <<< 30)) e = 64'sd1 <<< 30;
         for (int k = 0; k < 3; k++) begin
            e = (e * e + (64'sd1 <<< 29)) >>> 30;
         end
         num    = longint'(((64'sd1 <<< 30) - e) <<< 30);
         den    = longint'((64'sd1 <<< 30) + e);
         rom[i] = 31'(const_udiv(num + (den >> 1), den));
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = tanh_rom_build();

   function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
      logic signed [31:0] r;
      if (x > 72'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (x < -72'sd2147483648) r = 32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

@@ design/pid_controller_modes.sv @@
// pid_controller_modes: top level of the fixed-point pid step
// uses pidm_pkg, pidm_ctrl and pidm_datapath (which holds pidm_divider)
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_kind, req_target, req_measured,
//                                               req_time_step
//   rsp       out        rsp_valid / rsp_stall  rsp_drive, rsp_integral_now,
//                                               rsp_derivative_now
//   csr       in         csr_write              csr_index, csr_data
//
// one request at a time; a clear request goes from the idle state straight to the
// output state; a compute request runs through the bit-serial divider once for
// the derivative and, with the tanh limit, once more for the tanh table position
// a zero time step skips the derivative division
// reset is synchronous and active high; it restores register defaults and
// clears the loop state
// a finished result waits in the output register while the next request is
// taken; a stalled result holds only the last step of the following request
module pid_controller_modes
   import pidm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic signed [31:0]  req_target,
   input  logic signed [31:0]  req_measured,
   input  logic [23:0]         req_time_step,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_drive,
   output logic signed [31:0]  rsp_integral_now,
   output logic signed [31:0]  rsp_derivative_now,
   // register writes
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   cmd_type       cmd;
   dp_status_type status;

   // sequencer: one state per datapath step, the divider waits are the long ones
   pidm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: one shared 34x34 multiplier, one divider, the tanh table
   pidm_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index_type'(csr_index)),
      .csr_data           (csr_data),
      .req_target         (req_target),
      .req_measured       (req_measured),
      .req_time_step      (req_time_step),
      .rsp_drive          (rsp_drive),
      .rsp_integral_now   (rsp_integral_now),
      .rsp_derivative_now (rsp_derivative_now)
   );

endmodule

@@ design/pidm_divider.sv @@
// pidm_divider: unsigned restoring divider, one quotient bit per cycle
// uses pidm_pkg for the operand widths
module pidm_divider
   import pidm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff[DIV_DEN_W-1:0], num_ff[DIV_NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) den_ff <= divisor;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

@@ design/pidm_datapath.sv @@
// pidm_datapath: registers, shared multiplier, divider and tanh table lookup
// uses pidm_pkg and pidm_divider; driven by commands from pidm_ctrl
module pidm_datapath
   import pidm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output dp_status_type        status,
   input  logic                 csr_write,
   input  csr_index_type        csr_index,
   input  logic [31:0]          csr_data,
   input  logic signed [31:0]   req_target,
   input  logic signed [31:0]   req_measured,
   input  logic [23:0]          req_time_step,
   output logic signed [31:0]   rsp_drive,
   output logic signed [31:0]   rsp_integral_now,
   output logic signed [31:0]   rsp_derivative_now
);

   // configuration
   logic signed [23:0] kp_ff, ki_ff, kd_ff;
   logic signed [31:0] ilow_ff, ihigh_ff;
   logic               imode_ff, dmode_ff;
   logic [1:0]         smode_ff;

   // controller state
   logic signed [31:0] sum_ff, slope_ff, last_ff;

   // work registers
   logic signed [31:0] tgt_ff, meas_ff, err_ff, integ_ff, raw_ff, deriv_ff, t_ff;
   logic [23:0]        dt_ff;
   logic [30:0]        lo_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [71:0] acc_ff;
   logic signed [31:0] drive_ff, rsp_integ_ff, rsp_deriv_ff;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [32:0] err_sum, err_diff, raw_diff;
   logic [32:0]        diff_mag;
   logic [31:0]        h_mag, integ_mag;
   logic               div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quot;
   logic [DIV_DEN_W-1:0] div_den;
   logic               tanh_sat;
   logic [TANH_IDX_W-1:0] idx_safe, idx_next;
   logic [30:0]        rom_lo, rom_hi;
   logic signed [31:0] rom_step;
   logic signed [PROD_W-1:0] rs16, rs24, rs25, rs30;
   logic signed [71:0] integ_sum;
   logic signed [31:0] integ_sat, integ_lim, raw_val, deriv_val, tanh_val;
   logic signed [71:0] tanh_r, drive_r;

   assign err_sum  = 33'(err_ff) + 33'(last_ff);
   assign err_diff = 33'(err_ff) - 33'(last_ff);
   assign raw_diff = 33'(raw_ff) - 33'(slope_ff);
   assign diff_mag = err_diff[32] ? 33'(-err_diff) : 33'(err_diff);
   assign h_mag     = ihigh_ff[31] ? 32'(-ihigh_ff) : 32'(ihigh_ff);
   assign integ_mag = integ_ff[31] ? 32'(-integ_ff) : 32'(integ_ff);

   // tanh table interpolation points
   assign tanh_sat = div_quot >= (DIV_NUM_W'(TANH_TABLE_ENTRIES) << POS_FRAC);
   assign idx_safe = tanh_sat ? '0 : div_quot[POS_FRAC +: TANH_IDX_W];
   assign idx_next = idx_safe + 1'b1;
   assign rom_lo   = tanh_sat ? TANH_ROM[TANH_TABLE_ENTRIES] : TANH_ROM[idx_safe];
   assign rom_hi   = TANH_ROM[idx_next];
   assign rom_step = $signed({1'b0, rom_hi}) - $signed({1'b0, rom_lo});

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd)
         CMD_IMUL: begin
            mul_a = (imode_ff == IMODE_EULER) ? MUL_W'(err_ff) : MUL_W'(err_sum);
            mul_b = $signed(MUL_W'(dt_ff));
         end
         CMD_TINT: begin
            mul_a = tanh_sat ? '0 : MUL_W'(rom_step);
            mul_b = $signed(MUL_W'(div_quot[POS_FRAC-1:0]));
         end
         CMD_THMUL: begin
            mul_a = $signed(MUL_W'(h_mag));
            mul_b = MUL_W'(t_ff);
         end
         CMD_DFMUL: begin
            mul_a = MUL_W'(raw_diff);
            mul_b = MUL_W'(ALPHA_Q16);
         end
         CMD_MP: begin
            mul_a = MUL_W'(kp_ff);
            mul_b = MUL_W'(err_ff);
         end
         CMD_MI: begin
            mul_a = MUL_W'(ki_ff);
            mul_b = MUL_W'(integ_ff);
         end
         CMD_MD: begin
            mul_a = MUL_W'(kd_ff);
            mul_b = MUL_W'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (cmd)
         CMD_TDIV: begin
            div_start = 1'b1;
            div_num   = (DIV_NUM_W'(integ_mag) * DIV_NUM_W'(TANH_TABLE_ENTRIES)) << POS_FRAC;
            div_den   = {h_mag, 2'b00};
         end
         CMD_DDIV: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(diff_mag) << 24;
            div_den   = DIV_DEN_W'(dt_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   pidm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   // rounded shifts of the product register
   assign rs16 = (prod_ff + (PROD_W'(1) <<< 15)) >>> 16;
   assign rs24 = (prod_ff + (PROD_W'(1) <<< 23)) >>> 24;
   assign rs25 = (prod_ff + (PROD_W'(1) <<< 24)) >>> 25;
   assign rs30 = (prod_ff + (PROD_W'(1) <<< 29)) >>> 30;

   always_comb begin
      integ_sum = 72'(sum_ff) + ((imode_ff == IMODE_EULER) ? 72'(rs24) : 72'(rs25));
      integ_sat = sat32(integ_sum);
      integ_lim = integ_sat;
      case (smode_ff)
         SAT_CLAMP: begin
            if (integ_lim < ilow_ff) integ_lim = ilow_ff;
            if (integ_lim > ihigh_ff) integ_lim = ihigh_ff;
         end
         SAT_TANH: begin
            if (ihigh_ff == 32'sd0) integ_lim = '0;
         end
         default: begin
            integ_lim = integ_sat;
         end
      endcase
   end

   always_comb begin
      tanh_r   = integ_ff[31] ? -72'(rs30) : 72'(rs30);
      tanh_val = sat32(tanh_r);
      if (dt_ff == '0) begin
         raw_val = '0;
      end else if (!err_diff[32]) begin
         raw_val = (div_quot > DIV_NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                          : $signed(div_quot[31:0]);
      end else begin
         raw_val = (div_quot > DIV_NUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                          : -$signed(div_quot[31:0]);
      end
      if (dmode_ff == DMODE_RAW) deriv_val = raw_ff;
      else if (dt_ff == '0) deriv_val = slope_ff;
      else deriv_val = sat32(72'(slope_ff) + 72'(rs16));
      drive_r = (acc_ff + (72'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
   end

   assign status.div_done = div_done;
   assign status.tanh_on  = (smode_ff == SAT_TANH) && (ihigh_ff != 32'sd0);
   assign status.dt_zero  = dt_ff == '0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= KP_RESET;
         ki_ff    <= KI_RESET;
         kd_ff    <= KD_RESET;
         ilow_ff  <= ILOW_RESET;
         ihigh_ff <= IHIGH_RESET;
         imode_ff <= IMODE_EULER;
         smode_ff <= SAT_CLAMP;
         dmode_ff <= DMODE_FILTERED;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KP:    kp_ff    <= csr_data[23:0];
            CSR_KI:    ki_ff    <= csr_data[23:0];
            CSR_KD:    kd_ff    <= csr_data[23:0];
            CSR_ILOW:  ilow_ff  <= csr_data;
            CSR_IHIGH: ihigh_ff <= csr_data;
            CSR_IMODE: imode_ff <= csr_data[0];
            CSR_SMODE: smode_ff <= csr_data[1:0];
            CSR_DMODE: dmode_ff <= csr_data[0];
            default:   kp_ff    <= kp_ff;
         endcase
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset || cmd == CMD_CLR) begin
         sum_ff   <= '0;
         slope_ff <= '0;
         last_ff  <= '0;
      end else if (cmd == CMD_OUT) begin
         sum_ff   <= integ_ff;
         slope_ff <= deriv_ff;
         last_ff  <= err_ff;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd)
         CMD_LOAD: begin
            tgt_ff  <= req_target;
            meas_ff <= req_measured;
            dt_ff   <= req_time_step;
         end
         CMD_ERR:   err_ff   <= sat32(72'(tgt_ff) - 72'(meas_ff));
         CMD_IADD:  integ_ff <= integ_lim;
         CMD_TINT:  lo_ff    <= rom_lo;
         CMD_TSUM:  t_ff     <= 32'($signed({1'b0, lo_ff}) + rs16);
         CMD_TFIN:  integ_ff <= tanh_val;
         CMD_DRAW:  raw_ff   <= raw_val;
         CMD_DFADD: deriv_ff <= deriv_val;
         CMD_MI:    acc_ff   <= 72'(prod_ff);
         CMD_MD:    acc_ff   <= acc_ff + 72'(prod_ff);
         CMD_MA:    acc_ff   <= acc_ff + 72'(prod_ff);
         CMD_OUT: begin
            drive_ff     <= sat32(drive_r);
            rsp_integ_ff <= integ_ff;
            rsp_deriv_ff <= deriv_ff;
         end
         CMD_CLR: begin
            drive_ff     <= '0;
            rsp_integ_ff <= '0;
            rsp_deriv_ff <= '0;
         end
         default: begin
            t_ff <= t_ff;
         end
      endcase
   end

   assign rsp_drive          = drive_ff;
   assign rsp_integral_now   = rsp_integ_ff;
   assign rsp_derivative_now = rsp_deriv_ff;

endmodule

@@ design/pidm_ctrl.sv @@
// pidm_ctrl: sequencer for one control step and the request / result handshakes
// uses pidm_pkg for the command and status types
module pidm_ctrl
   import pidm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_kind,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output cmd_type       cmd
);

   typedef enum logic [19:0] {
      S_IDLE  = 20'h00001,
      S_ERR   = 20'h00002,
      S_IMUL  = 20'h00004,
      S_IADD  = 20'h00008,
      S_TDIV  = 20'h00010,
      S_TWAIT = 20'h00020,
      S_TINT  = 20'h00040,
      S_TSUM  = 20'h00080,
      S_THMUL = 20'h00100,
      S_TFIN  = 20'h00200,
      S_DDIV  = 20'h00400,
      S_DWAIT = 20'h00800,
      S_DRAW  = 20'h01000,
      S_DFMUL = 20'h02000,
      S_DFADD = 20'h04000,
      S_MP    = 20'h08000,
      S_MI    = 20'h10000,
      S_MD    = 20'h20000,
      S_MA    = 20'h40000,
      S_OUT   = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   logic      kind_ff, kind_in;
   logic      rsp_valid_ff, rsp_valid_in;
   state_type deriv_start;

   assign deriv_start = status.dt_zero ? S_DRAW : S_DDIV;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               kind_in  = req_kind;
               state_in = req_kind ? S_OUT : S_ERR;
            end
         end
         S_ERR: begin
            cmd      = CMD_ERR;
            state_in = S_IMUL;
         end
         S_IMUL: begin
            cmd      = CMD_IMUL;
            state_in = S_IADD;
         end
         S_IADD: begin
            cmd      = CMD_IADD;
            state_in = status.tanh_on ? S_TDIV : deriv_start;
         end
         S_TDIV: begin
            cmd      = CMD_TDIV;
            state_in = S_TWAIT;
         end
         S_TWAIT: begin
            if (status.div_done) state_in = S_TINT;
         end
         S_TINT: begin
            cmd      = CMD_TINT;
            state_in = S_TSUM;
         end
         S_TSUM: begin
            cmd      = CMD_TSUM;
            state_in = S_THMUL;
         end
         S_THMUL: begin
            cmd      = CMD_THMUL;
            state_in = S_TFIN;
         end
         S_TFIN: begin
            cmd      = CMD_TFIN;
            state_in = deriv_start;
         end
         S_DDIV: begin
            cmd      = CMD_DDIV;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (status.div_done) state_in = S_DRAW;
         end
         S_DRAW: begin
            cmd      = CMD_DRAW;
            state_in = S_DFMUL;
         end
         S_DFMUL: begin
            cmd      = CMD_DFMUL;
            state_in = S_DFADD;
         end
         S_DFADD: begin
            cmd      = CMD_DFADD;
            state_in = S_MP;
         end
         S_MP: begin
            cmd      = CMD_MP;
            state_in = S_MI;
         end
         S_MI: begin
            cmd      = CMD_MI;
            state_in = S_MD;
         end
         S_MD: begin
            cmd      = CMD_MD;
            state_in = S_MA;
         end
         S_MA: begin
            cmd      = CMD_MA;
            state_in = S_OUT;
         end
         S_OUT: begin
            // result register free or being taken this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd          = kind_ff ? CMD_CLR : CMD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ tb/sv/pid_controller_modes_tb.sv @@
// pid_controller_modes_tb: self-checking testbench of the fixed-point pid step
// depends on pidm_pkg for the register index names and on pid_controller_modes
`timescale 1ns / 100ps

module pid_controller_modes_tb
   import pidm_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ROM_N          = 256;
   localparam logic KIND_COMPUTE = 1'b0;
   localparam logic KIND_CLEAR   = 1'b1;
   localparam logic [1:0] SAT_UNUSED = 2'd3;

   typedef struct {
      logic signed [31:0] drive;
      logic signed [31:0] integ;
      logic signed [31:0] deriv;
   } pid_result_type;

   // scoreboard: own copy of registers and loop state, queue of expected results
   class pid_scoreboard;
      logic signed [23:0] kp, ki, kd;
      logic signed [31:0] bound_low, bound_high;
      logic               trapezoid;
      logic [1:0]         limit_mode;
      logic               filtered;
      longint             integ_sum, slope_sum, last_err;
      longint             tanh_tab [0:ROM_N];
      pid_result_type     pending_q [$];
      int                 mismatches;
      int                 checked;

      function new();
         longint w, term, e, p, num, den;
         for (int i = 0; i <= ROM_N; i++) begin
            w    = (longint'(i) <<< 30) / ROM_N;
            term = 64'sd1 <<< 30;
            e    = term;
            for (int k = 1; k <= 20; k++) begin
               p    = rnd(term * w, 30);
               term = -(p / k);
               e    = e + term;
            end
            if (e < 0) e = 0;
            if (e > (64'sd1 <<< 30)) e = 64'sd1 <<< 30;
            repeat (3) e = rnd(e * e, 30);
            num = ((64'sd1 <<< 30) - e) <<< 30;
            den = (64'sd1 <<< 30) + e;
            tanh_tab[i] = (num + den / 2) / den;
         end
         mismatches = 0;
         checked    = 0;
         defaults();
      endfunction

      function void defaults();
         kp = 24'sd131072; ki = 24'sd32768; kd = 24'sd6554;
         bound_low = -32'sd655360; bound_high = 32'sd655360;
         trapezoid = IMODE_EULER; limit_mode = SAT_CLAMP; filtered = DMODE_FILTERED;
         integ_sum = 0; slope_sum = 0; last_err = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] data);
         case (idx)
            CSR_KP:    kp = data[23:0];
            CSR_KI:    ki = data[23:0];
            CSR_KD:    kd = data[23:0];
            CSR_ILOW:  bound_low = data;
            CSR_IHIGH: bound_high = data;
            CSR_IMODE: trapezoid = data[0];
            CSR_SMODE: limit_mode = data[1:0];
            CSR_DMODE: filtered = data[0];
            default:   kp = kp;
         endcase
      endfunction

      static function longint rnd(longint x, int n);
         return (x + (64'sd1 <<< (n - 1))) >>> n;
      endfunction

      static function longint clip32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function longint tanh_limit(longint v);
         longint h, a, pos, idx, frac, t, r;
         if (bound_high == 0) return 0;
         h   = bound_high < 0 ? -longint'(bound_high) : longint'(bound_high);
         a   = v < 0 ? -v : v;
         pos = ((a * ROM_N) <<< 16) / (h * 4);
         idx = pos >>> 16;
         frac = pos & 64'hFFFF;
         if (idx >= ROM_N) t = tanh_tab[ROM_N];
         else t = tanh_tab[idx] + rnd((tanh_tab[idx + 1] - tanh_tab[idx]) * frac, 16);
         r = rnd(h * t, 30);
         return clip32(v < 0 ? -r : r);
      endfunction

      function void note_request(logic kind, logic signed [31:0] tgt,
                                 logic signed [31:0] meas, logic [23:0] step);
         pid_result_type res;
         longint err, dt, integ, raw, deriv, acc;
         if (kind == KIND_CLEAR) begin
            integ_sum = 0; slope_sum = 0; last_err = 0;
            res.drive = 0; res.integ = 0; res.deriv = 0;
            pending_q.push_back(res);
            return;
         end
         dt  = longint'(step);
         err = clip32(longint'(tgt) - longint'(meas));
         if (trapezoid) integ = integ_sum + rnd((err + last_err) * dt, 25);
         else integ = integ_sum + rnd(err * dt, 24);
         integ = clip32(integ);
         if (limit_mode == SAT_CLAMP) begin
            if (integ < bound_low) integ = bound_low;
            if (integ > bound_high) integ = bound_high;
         end else if (limit_mode == SAT_TANH) begin
            integ = tanh_limit(integ);
         end
         raw = 0;
         if (dt != 0) raw = clip32(((err - last_err) <<< 24) / dt);
         if (!filtered) deriv = raw;
         else if (dt == 0) deriv = slope_sum;
         else deriv = clip32(slope_sum + rnd((raw - slope_sum) * ALPHA_Q16, 16));
         acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * deriv;
         acc = clip32(rnd(acc, FRACTION_BITS));
         integ_sum = integ; slope_sum = deriv; last_err = err;
         res.drive = acc; res.integ = integ; res.deriv = deriv;
         pending_q.push_back(res);
      endfunction

      function void check_result(logic signed [31:0] drive, logic signed [31:0] integ,
                                 logic signed [31:0] deriv);
         pid_result_type exp_res;
         checked++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result drive=%0d", drive);
            return;
         end
         exp_res = pending_q.pop_front();
         if (drive !== exp_res.drive || integ !== exp_res.integ
             || deriv !== exp_res.deriv) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                        checked, exp_res.drive, exp_res.integ, exp_res.deriv,
                        drive, integ, deriv);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = KIND_COMPUTE;
   logic signed [31:0] req_target = '0;
   logic signed [31:0] req_measured = '0;
   logic [23:0]        req_time_step = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_drive;
   logic signed [31:0] rsp_integral_now;
   logic signed [31:0] rsp_derivative_now;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = CSR_KP;
   logic [31:0]        csr_data = '0;

   pid_scoreboard sb = new();
   bit  quiet = 1'b0;      // no idling on either side in the closing stretch
   int  idle_cycles = 0;
   int  stall_left = 0;
   int  n_compute = 0;
   int  n_clear = 0;

   always #1 clock = ~clock;

   pid_controller_modes u_dut (.*);

   // result side stalls in short random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // monitor: handshakes at the rising edge, values settled since the falling edge
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_drive, rsp_integral_now, rsp_derivative_now);
            idle_cycles = 0;
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_kind, req_target, req_measured, req_time_step);
            if (req_kind == KIND_CLEAR) n_clear++;
            else n_compute++;
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", sb.pending_q.size());
            $display("pid_controller_modes regression: fail");
            $finish;
         end
      end
   end

   // send one request, holding it until accepted
   task automatic send_request(logic kind, logic signed [31:0] tgt,
                               logic signed [31:0] meas, logic [23:0] step);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_kind      = kind;
      req_target    = tgt;
      req_measured  = meas;
      req_time_step = step;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // register write, only once every result has drained
   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      req_valid = 1'b0;
      wait (sb.pending_q.size() == 0);
      repeat (10) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic set_modes(logic imode, logic [1:0] smode, logic dmode);
      write_csr(CSR_IMODE, {31'b0, imode});
      write_csr(CSR_SMODE, {30'b0, smode});
      write_csr(CSR_DMODE, {31'b0, dmode});
   endtask

   // mostly moderate signals so the loop state moves, now and then full range
   function automatic logic [31:0] pick_signal();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom();
         2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2 * 1310720)) - 1310720);
      endcase
   endfunction

   function automatic logic [23:0] pick_step();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return 24'hFF_FFFF;
         2, 3:    return 24'($urandom());
         default: return 24'($urandom_range(1, 24'h02_0000));
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return 32'h0080_0000;
         1:       return 32'h007F_FFFF;
         2:       return $urandom();
         default: return 32'($signed($urandom_range(0, 262144)) - 65536);
      endcase
   endfunction

   initial begin
      logic [31:0] lo, hi;
      int          phase_items;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: defaults first, field extremes, both step extremes
      send_request(KIND_COMPUTE, 32'sh0001_0000, 32'sh0, 24'h01_0000);
      send_request(KIND_COMPUTE, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF);
      send_request(KIND_COMPUTE, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'h00_0001);
      send_request(KIND_COMPUTE, 32'sh0, 32'sh0002_0000, 24'h0);  // zero step, filter holds
      send_request(KIND_CLEAR, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 24'hFF_FFFF);
      // raw derivative, trapezoid, no limit, extreme gains
      set_modes(IMODE_TRAPEZOID, SAT_NONE, DMODE_RAW);
      write_csr(CSR_KP, 32'h0080_0000);
      write_csr(CSR_KI, 32'h007F_FFFF);
      write_csr(CSR_KD, 32'h0080_0000);
      send_request(KIND_COMPUTE, 32'sh4000_0000, 32'shC000_0000, 24'hFF_FFFF);
      send_request(KIND_COMPUTE, 32'sh4000_0000, 32'shC000_0000, 24'hFF_FFFF);
      send_request(KIND_COMPUTE, 32'sh0, 32'sh0, 24'h0);         // zero step, raw gives 0
      send_request(KIND_COMPUTE, 32'sh8000_0000, 32'sh0, 24'h00_0001);
      // unused limit mode behaves as no limit
      write_csr(CSR_SMODE, {30'b0, SAT_UNUSED});
      send_request(KIND_COMPUTE, 32'sh7FFF_FFFF, 32'sh0, 24'hFF_FFFF);
      // clamp with crossed bounds lands on the upper bound
      write_csr(CSR_SMODE, {30'b0, SAT_CLAMP});
      write_csr(CSR_ILOW, 32'sd1000000);
      write_csr(CSR_IHIGH, -32'sd1000000);
      send_request(KIND_COMPUTE, 32'sh0003_0000, 32'sh0, 24'h80_0000);
      send_request(KIND_CLEAR, 32'sh0, 32'sh0, 24'h0);
      // tanh limit: negative scale, zero scale, saturated table end
      write_csr(CSR_SMODE, {30'b0, SAT_TANH});
      send_request(KIND_COMPUTE, 32'sh0008_0000, 32'sh0, 24'h40_0000);
      send_request(KIND_COMPUTE, 32'sh8000_0000, 32'sh0, 24'hFF_FFFF);
      write_csr(CSR_IHIGH, 32'sh0);
      send_request(KIND_COMPUTE, 32'sh0005_0000, 32'sh0, 24'h80_0000);
      write_csr(CSR_IHIGH, 32'sh7FFF_FFFF);
      write_csr(CSR_ILOW, 32'sh8000_0000);
      send_request(KIND_COMPUTE, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF);
      write_csr(CSR_IHIGH, 32'sh8000_0000);
      send_request(KIND_COMPUTE, 32'sh0100_0000, 32'sh0, 24'h10_0000);
      set_modes(IMODE_EULER, SAT_TANH, DMODE_FILTERED);
      send_request(KIND_COMPUTE, 32'shF000_0000, 32'sh0, 24'h0);

      // random phases, each with a fresh register setting
      for (int phase = 0; phase < 12; phase++) begin
         write_csr(CSR_KP, pick_gain());
         write_csr(CSR_KI, pick_gain());
         write_csr(CSR_KD, pick_gain());
         case ($urandom_range(0, 5))
            0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
            1: begin lo = $urandom(); hi = $urandom(); end
            default: begin
               hi = $urandom_range(1, 32'h0100_0000);
               lo = -$signed(hi);
            end
         endcase
         write_csr(CSR_ILOW, lo);
         write_csr(CSR_IHIGH, hi);
         set_modes(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
         if (phase == 11) quiet = 1'b1;
         phase_items = 125;
         for (int n = 0; n < phase_items; n++) begin
            if ($urandom_range(0, 19) == 0)
               send_request(KIND_CLEAR, $urandom(), $urandom(), 24'($urandom()));
            else
               send_request(KIND_COMPUTE, pick_signal(), pick_signal(), pick_step());
         end
      end

      req_valid = 1'b0;
      wait (sb.pending_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d compute and %0d clear requests, %0d results checked",
               n_compute, n_clear, sb.checked);
      $display("all integration, limit and derivative modes over 12 random settings");
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("pid_controller_modes regression: pass");
      else
         $display("pid_controller_modes regression: fail");
      $finish;
   end

endmodule
